// ----- src/abml_pkg.sv -----
// Shared types, constants and register codes for the audio buffer level monitor.
package abml_pkg;

  localparam int LevelBitsDefault = 17;
  localparam int ReqTypeBits      = 2;
  localparam int AmountBits       = 12;
  localparam int LimitBits        = 16;
  localparam int XferBits         = 12;
  localparam int CfgIdxBits       = 2;
  localparam int CfgDataBits      = 16;

  localparam logic [LimitBits-1:0] ActiveLimitRst   = 16'd8192;
  localparam logic [LimitBits-1:0] UnderflowLimitRst = 16'd0;
  localparam logic [LimitBits-1:0] OverflowLimitRst = 16'd14336;
  localparam logic [XferBits-1:0]  XferSizeRst      = 12'd192;

  typedef enum logic [ReqTypeBits-1:0] {
    ReqArrival  = 2'd0,
    ReqXferDone = 2'd1,
    ReqTimeout  = 2'd2
  } req_type_e;

  typedef enum logic [CfgIdxBits-1:0] {
    CfgActiveLimit    = 2'd0,
    CfgUnderflowLimit = 2'd1,
    CfgOverflowLimit  = 2'd2,
    CfgXferBytes      = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [LimitBits-1:0] active_limit;
    logic [LimitBits-1:0] underflow_limit;
    logic [LimitBits-1:0] overflow_limit;
    logic [XferBits-1:0]  xfer_bytes;
  } cfg_t;

  typedef struct packed {
    logic active;
    logic overflow;
  } status_t;

  typedef struct packed {
    logic dropped;
    logic enabled_now;
    logic disabled_now;
  } evt_t;

endpackage

// ----- src/abml_if.sv -----
// Request and result channel interfaces of the audio buffer level monitor.
interface abml_req_if;
  import abml_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [ReqTypeBits-1:0] req_type;
  logic [AmountBits-1:0]  amount;

  modport source (output valid, output req_type, output amount, input ready);
  modport sink   (input valid, input req_type, input amount, output ready);
endinterface

interface abml_res_if #(
  parameter int LevelBits = abml_pkg::LevelBitsDefault
);
  logic                        valid;
  logic                        ready;
  logic signed [LevelBits-1:0] level;
  logic                        active;
  logic                        overflow;
  logic                        dropped;
  logic                        enabled_now;
  logic                        disabled_now;

  modport source (output valid, output level, output active, output overflow,
                  output dropped, output enabled_now, output disabled_now, input ready);
  modport sink   (input valid, input level, input active, input overflow,
                  input dropped, input enabled_now, input disabled_now, output ready);
endinterface

// ----- src/abml_cfg_regs.sv -----
// Configuration register file: limits and transfer size.
module abml_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [abml_pkg::CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [abml_pkg::CfgDataBits-1:0] cfg_wdata_i,
  output abml_pkg::cfg_t                   cfg_o
);
  import abml_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgActiveLimit:    cfg_d.active_limit    = cfg_wdata_i[LimitBits-1:0];
        CfgUnderflowLimit: cfg_d.underflow_limit = cfg_wdata_i[LimitBits-1:0];
        CfgOverflowLimit:  cfg_d.overflow_limit  = cfg_wdata_i[LimitBits-1:0];
        CfgXferBytes:      cfg_d.xfer_bytes      = cfg_wdata_i[XferBits-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.active_limit    <= ActiveLimitRst;
      cfg_q.underflow_limit <= UnderflowLimitRst;
      cfg_q.overflow_limit  <= OverflowLimitRst;
      cfg_q.xfer_bytes      <= XferSizeRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;
endmodule

// ----- src/abml_core.sv -----
// Event logic: saturating level update, output enable and overflow flag decisions.
module abml_core #(
  parameter int LevelBits = abml_pkg::LevelBitsDefault
) (
  input  logic [abml_pkg::ReqTypeBits-1:0] req_type_i,
  input  logic [abml_pkg::AmountBits-1:0]  amount_i,
  input  abml_pkg::cfg_t                   cfg_i,
  input  logic signed [LevelBits-1:0]      level_i,
  input  abml_pkg::status_t                status_i,
  output logic signed [LevelBits-1:0]      level_o,
  output abml_pkg::status_t                status_o,
  output abml_pkg::evt_t                   evt_o
);
  import abml_pkg::*;

  // Wide enough for the level, any limit and one add or subtract without wrap.
  localparam int Ew = ((LevelBits > LimitBits) ? LevelBits : LimitBits) + 2;

  localparam logic signed [Ew-1:0] LvlMax = {{(Ew-LevelBits+1){1'b0}}, {(LevelBits-1){1'b1}}};
  localparam logic signed [Ew-1:0] LvlMin = {{(Ew-LevelBits+1){1'b1}}, {(LevelBits-1){1'b0}}};

  logic signed [Ew-1:0] lvl_ext, amount_ext, size_ext;
  logic signed [Ew-1:0] act_lim, udf_lim, ovf_lim;
  logic signed [Ew-1:0] sum_raw, diff_raw, sum_sat, diff_sat, lvl_new;

  function automatic logic signed [Ew-1:0] sat(input logic signed [Ew-1:0] v);
    logic signed [Ew-1:0] r;
    r = v;
    if (v > LvlMax) r = LvlMax;
    if (v < LvlMin) r = LvlMin;
    return r;
  endfunction

  assign lvl_ext    = $signed({{(Ew-LevelBits){level_i[LevelBits-1]}}, level_i});
  assign amount_ext = $signed({{(Ew-AmountBits){1'b0}}, amount_i});
  assign size_ext   = $signed({{(Ew-XferBits){1'b0}}, cfg_i.xfer_bytes});
  assign act_lim    = $signed({{(Ew-LimitBits){1'b0}}, cfg_i.active_limit});
  assign udf_lim    = $signed({{(Ew-LimitBits){1'b0}}, cfg_i.underflow_limit});
  assign ovf_lim    = $signed({{(Ew-LimitBits){1'b0}}, cfg_i.overflow_limit});

  assign sum_raw  = lvl_ext + amount_ext;
  assign diff_raw = lvl_ext - size_ext;
  assign sum_sat  = sat(sum_raw);
  assign diff_sat = sat(diff_raw);

  always_comb begin
    lvl_new  = lvl_ext;
    status_o = status_i;
    evt_o    = '0;
    case (req_type_e'(req_type_i))
      ReqArrival: begin
        if (status_i.overflow) evt_o.dropped = 1'b1;
        else lvl_new = sum_sat;
      end
      ReqXferDone: begin
        lvl_new = diff_sat;
        if (diff_sat <= udf_lim) begin
          evt_o.disabled_now = status_i.active;
          status_o.active    = 1'b0;
        end
        // clear test takes priority over set when the flag is already up
        if (status_i.overflow) begin
          if (diff_sat <= act_lim) status_o.overflow = 1'b0;
        end else if (diff_sat >= ovf_lim) begin
          status_o.overflow = 1'b1;
        end
      end
      ReqTimeout: begin
        if (!status_i.active && (lvl_ext >= act_lim)) begin
          status_o.active   = 1'b1;
          evt_o.enabled_now = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign level_o = lvl_new[LevelBits-1:0];
endmodule

// ----- src/audio_buffer_level_monitor.sv -----
// Top level of the audio buffer level monitor: request register, state, result register.
// An accepted request waits in the request register; when it advances, its result is captured in the result register.
// Throughput: one request per cycle while the result side takes one per cycle;
//   the level state is read and written in the single compute stage, so each
//   request sees the state left by the one before it.
// Reset: rst_ni low clears level, active and overflow, empties both stages and
//   loads the limit registers with their default values.
module audio_buffer_level_monitor #(
  parameter int LevelBits = abml_pkg::LevelBitsDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  abml_req_if.sink                         req,
  abml_res_if.source                       res,
  input  logic                             cfg_we_i,
  input  logic [abml_pkg::CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [abml_pkg::CfgDataBits-1:0] cfg_wdata_i
);
  import abml_pkg::*;

  cfg_t cfg;

  // Request register
  logic                   s1_valid_q, s1_valid_d;
  logic [ReqTypeBits-1:0] s1_req_type_q;
  logic [AmountBits-1:0]  s1_amount_q;

  // Buffer state
  logic signed [LevelBits-1:0] level_q;
  status_t                     status_q;

  // Result register
  logic                        out_valid_q, out_valid_d;
  logic signed [LevelBits-1:0] out_level_q;
  status_t                     out_status_q;
  evt_t                        out_evt_q;

  // Core outputs
  logic signed [LevelBits-1:0] level_d;
  status_t                     status_d;
  evt_t                        evt_d;

  logic req_take, advance;

  abml_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  abml_core #(.LevelBits(LevelBits)) u_core (
    .req_type_i (s1_req_type_q),
    .amount_i   (s1_amount_q),
    .cfg_i      (cfg),
    .level_i    (level_q),
    .status_i   (status_q),
    .level_o    (level_d),
    .status_o   (status_d),
    .evt_o      (evt_d)
  );

  // Advance the held request when the result register is empty or being drained.
  assign advance   = s1_valid_q && (!out_valid_q || res.ready);
  // Take a new request whenever the request register is empty or empties in this cycle.
  assign req.ready = !s1_valid_q || advance;
  assign req_take  = req.valid && req.ready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (req_take)     s1_valid_d = 1'b1;
    else if (advance) s1_valid_d = 1'b0;

    out_valid_d = out_valid_q;
    if (advance)        out_valid_d = 1'b1;
    else if (res.ready) out_valid_d = 1'b0;
  end

  // Control and state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      level_q     <= '0;
      status_q    <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        level_q  <= level_d;
        status_q <= status_d;
      end
    end
  end

  // Payload: hold the request, capture the result
  always_ff @(posedge clk_i) begin
    if (req_take) begin
      s1_req_type_q <= req.req_type;
      s1_amount_q   <= req.amount;
    end
    if (advance) begin
      out_level_q  <= level_d;
      out_status_q <= status_d;
      out_evt_q    <= evt_d;
    end
  end

  assign res.valid        = out_valid_q;
  assign res.level        = out_level_q;
  assign res.active       = out_status_q.active;
  assign res.overflow     = out_status_q.overflow;
  assign res.dropped      = out_evt_q.dropped;
  assign res.enabled_now  = out_evt_q.enabled_now;
  assign res.disabled_now = out_evt_q.disabled_now;
endmodule

// ----- src/abml_checker.sv -----
// Port-level checks on the result channel of the audio buffer level monitor.
module abml_assert (
  input logic clk_i,
  input logic rst_ni,
  input logic res_valid,
  input logic res_ready,
  input logic res_active,
  input logic res_overflow,
  input logic res_dropped,
  input logic res_enabled_now,
  input logic res_disabled_now
);

  // Hold a stalled result
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped while stalled");

  // A dropped arrival can only happen with the overflow flag up, and arrivals never clear it
  a_drop_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res_dropped |-> res_overflow)
    else $error("arrival dropped without overflow");

  // Each event reports at most one kind of side effect
  a_one_evt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> $countones({res_dropped, res_enabled_now, res_disabled_now}) <= 1)
    else $error("more than one event flag set");

  // Switching output on or off must match the reported active state
  a_act_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && (res_enabled_now || res_disabled_now) |-> (res_active == res_enabled_now))
    else $error("active state disagrees with switch flag");

endmodule

bind audio_buffer_level_monitor abml_assert u_abml_assert (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .res_valid        (res.valid),
  .res_ready        (res.ready),
  .res_active       (res.active),
  .res_overflow     (res.overflow),
  .res_dropped      (res.dropped),
  .res_enabled_now  (res.enabled_now),
  .res_disabled_now (res.disabled_now)
);
